@@ hdl/miis_pkg.sv @@
// Shared types, codes and decode helpers for the MIPS integer step block.
package miis_pkg;

  localparam logic [31:0] BOOT_PC     = 32'hA4000040;
  localparam logic [31:0] REGION_MASK = 32'hF0000000;
  localparam logic [63:0] BOOT_HI     = 64'h000000003FC18657;
  localparam logic [63:0] BOOT_LO     = 64'h000000003103E121;

  localparam int REG_AW = 5;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_LOAD   = 2'd1;
  localparam logic [1:0] ST_UNIMPL = 2'd2;

  localparam logic [2:0] LK_NONE = 3'd0;
  localparam logic [2:0] LK_LBU  = 3'd1;
  localparam logic [2:0] LK_LHU  = 3'd2;
  localparam logic [2:0] LK_LW   = 3'd3;
  localparam logic [2:0] LK_LWU  = 3'd4;
  localparam logic [2:0] LK_LD   = 3'd5;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_DBL  = 2'd3;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_BEQL    = 6'h14;
  localparam logic [5:0] OP_BNEL    = 6'h15;
  localparam logic [5:0] OP_DADDI   = 6'h18;
  localparam logic [5:0] OP_DADDIU  = 6'h19;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_LWU     = 6'h27;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] OP_CACHE   = 6'h2F;
  localparam logic [5:0] OP_LD      = 6'h37;

  localparam logic [5:0] F_SLL    = 6'h00;
  localparam logic [5:0] F_SRL    = 6'h02;
  localparam logic [5:0] F_SRA    = 6'h03;
  localparam logic [5:0] F_SLLV   = 6'h04;
  localparam logic [5:0] F_SRLV   = 6'h06;
  localparam logic [5:0] F_SRAV   = 6'h07;
  localparam logic [5:0] F_JR     = 6'h08;
  localparam logic [5:0] F_JALR   = 6'h09;
  localparam logic [5:0] F_MFLO   = 6'h12;
  localparam logic [5:0] F_DSLLV  = 6'h14;
  localparam logic [5:0] F_MULTU  = 6'h19;
  localparam logic [5:0] F_ADD    = 6'h20;
  localparam logic [5:0] F_ADDU   = 6'h21;
  localparam logic [5:0] F_SUBU   = 6'h23;
  localparam logic [5:0] F_AND    = 6'h24;
  localparam logic [5:0] F_OR     = 6'h25;
  localparam logic [5:0] F_XOR    = 6'h26;
  localparam logic [5:0] F_NOR    = 6'h27;
  localparam logic [5:0] F_SLT    = 6'h2A;
  localparam logic [5:0] F_SLTU   = 6'h2B;
  localparam logic [5:0] F_DSLL   = 6'h38;
  localparam logic [5:0] F_DSLL32 = 6'h3C;
  localparam logic [5:0] F_DSRA32 = 6'h3F;

  localparam logic [4:0] RT_BGEZAL = 5'h11;
  localparam logic [4:0] RS_MTC0   = 5'h04;
  localparam logic [4:0] LINK_REG  = 5'd31;

  typedef struct packed {
    logic        is_data;
    logic        unimpl;
    logic [31:0] iw;
    logic [63:0] load_data;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] fetch_address;
    logic        mem_read;
    logic        mem_write;
    logic [1:0]  mem_size;
    logic [31:0] mem_address;
    logic [31:0] store_data;
  } result_t;

  function automatic logic [63:0] sx32(input logic [63:0] v);
    sx32 = {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic is_unimpl(input logic [31:0] iw);
    logic [5:0] op;
    logic [5:0] fn;
    op = iw[31:26];
    fn = iw[5:0];
    case (op)
      OP_SPECIAL: is_unimpl = !(fn inside {F_SLL, F_SRL, F_SRA, F_SLLV, F_SRLV, F_SRAV,
                                           F_JR, F_JALR, F_MFLO, F_DSLLV, F_MULTU, F_ADD,
                                           F_ADDU, F_SUBU, F_AND, F_OR, F_XOR, F_NOR,
                                           F_SLT, F_SLTU, F_DSLL, F_DSLL32, F_DSRA32});
      OP_REGIMM:  is_unimpl = (iw[20:16] != RT_BGEZAL);
      OP_COP0:    is_unimpl = (iw[25:21] != RS_MTC0);
      default:    is_unimpl = !(op inside {OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU,
                                           OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI,
                                           OP_LUI, OP_BEQL, OP_BNEL, OP_DADDI, OP_DADDIU,
                                           OP_LW, OP_LBU, OP_LHU, OP_LWU, OP_SW,
                                           OP_CACHE, OP_LD});
    endcase
  endfunction

  function automatic logic [63:0] boot_reg(input logic [4:0] i);
    case (i)
      5'd1:    boot_reg = 64'h1;
      5'd2:    boot_reg = 64'hEBDA536;
      5'd3:    boot_reg = 64'hEBDA536;
      5'd4:    boot_reg = 64'hA536;
      5'd5:    boot_reg = 64'hFFFFFFFFC0F1D859;
      5'd6:    boot_reg = 64'hFFFFFFFFA4001F0C;
      5'd7:    boot_reg = 64'hFFFFFFFFA4001F08;
      5'd8:    boot_reg = 64'hC0;
      5'd10:   boot_reg = 64'h40;
      5'd11:   boot_reg = 64'hFFFFFFFFA4000040;
      5'd12:   boot_reg = 64'hFFFFFFFFED10D0B3;
      5'd13:   boot_reg = 64'h1402A4CC;
      5'd14:   boot_reg = 64'h2DE108EA;
      5'd15:   boot_reg = 64'h3103E121;
      5'd20:   boot_reg = 64'h1;
      5'd22:   boot_reg = 64'h3F;
      5'd25:   boot_reg = 64'hFFFFFFFF9DEBB54F;
      5'd29:   boot_reg = 64'hFFFFFFFFA4001FF0;
      5'd31:   boot_reg = 64'hFFFFFFFFA4001550;
      default: boot_reg = 64'h0;
    endcase
  endfunction

endpackage

@@ hdl/miis_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module miis_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/miis_front.sv @@
// Front end: accept items, flag unimplemented instructions, queue them.
module miis_front #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic [31:0]          in_instruction_word,
  input  logic [63:0]          in_load_data,
  output logic                 q_valid,
  output miis_pkg::item_t      q_item,
  input  logic                 q_pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  miis_pkg::item_t slot_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push;
  miis_pkg::item_t new_item;

  assign in_ready = (cnt_r != CW'(DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = slot_r[rp_r];

  always_comb begin
    new_item.is_data   = in_opcode;
    new_item.unimpl    = !in_opcode && miis_pkg::is_unimpl(in_instruction_word);
    new_item.iw        = in_instruction_word;
    new_item.load_data = in_load_data;
  end

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (q_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= new_item;
    end
  end

endmodule

@@ hdl/miis_back.sv @@
// Back end: register file, execute stage, architectural state, result register.
module miis_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  input  logic                q_valid,
  input  miis_pkg::item_t     q_item,
  output logic                q_pop,
  input  logic                out_ready,
  output logic                out_valid,
  output miis_pkg::result_t   out_res
);

  localparam int RN = 32;

  // execute stage
  logic             ex_v_r;
  miis_pkg::item_t  ex_r;
  logic             fire;
  logic             w_go;

  // architectural state
  logic [31:0] pc_r, npc_r;
  logic [63:0] hi_r, lo_r;
  logic [2:0]  lk_r;
  logic [4:0]  lt_r;
  logic [RN-1:0] vld_r;

  // most recent register write, covers the read-during-write case
  logic        fwd_v_r;
  logic [4:0]  fwd_a_r;
  logic [63:0] fwd_d_r;

  logic [63:0] ram_a, ram_b, a, b;
  logic [4:0]  rs, rt, rd, sa, q_rs, q_rt;
  logic [5:0]  op, fn;
  logic [63:0] imm, zimm;

  // execute results
  logic              wr_en;
  logic [4:0]        wr_a;
  logic [63:0]       wr_d;
  logic              take;
  logic [31:0]       nf, pc_nxt, npc_nxt;
  logic              mul_en;
  logic [63:0]       prod;
  logic [2:0]        lk_nxt;
  logic [4:0]        lt_nxt;
  miis_pkg::result_t res;
  logic [31:0]       pc4, link32, br_tgt, j_tgt, t32;
  logic [63:0]       ld_v;

  assign fire  = ex_v_r && (!out_valid || out_ready);
  assign q_pop = q_valid && (!ex_v_r || fire);
  assign q_rs  = q_item.iw[25:21];
  assign q_rt  = q_item.iw[20:16];

  // gate state updates with fire; hold them while the result register is full
  assign w_go = fire && wr_en;

  miis_ram #(.WIDTH(64), .DEPTH(RN)) u_ram_a (
    .clk(clk), .we(w_go), .waddr(wr_a), .wdata(wr_d),
    .re(q_pop), .raddr(q_rs), .rdata(ram_a)
  );

  miis_ram #(.WIDTH(64), .DEPTH(RN)) u_ram_b (
    .clk(clk), .we(w_go), .waddr(wr_a), .wdata(wr_d),
    .re(q_pop), .raddr(q_rt), .rdata(ram_b)
  );

  assign op   = ex_r.iw[31:26];
  assign fn   = ex_r.iw[5:0];
  assign rs   = ex_r.iw[25:21];
  assign rt   = ex_r.iw[20:16];
  assign rd   = ex_r.iw[15:11];
  assign sa   = ex_r.iw[10:6];
  assign imm  = {{48{ex_r.iw[15]}}, ex_r.iw[15:0]};
  assign zimm = {48'b0, ex_r.iw[15:0]};

  always_comb begin
    if (fwd_v_r && fwd_a_r == rs) begin
      a = fwd_d_r;
    end else if (vld_r[rs]) begin
      a = ram_a;
    end else begin
      a = miis_pkg::boot_reg(rs);
    end
    if (fwd_v_r && fwd_a_r == rt) begin
      b = fwd_d_r;
    end else if (vld_r[rt]) begin
      b = ram_b;
    end else begin
      b = miis_pkg::boot_reg(rt);
    end
  end

  assign pc4    = pc_r + 32'd4;
  assign link32 = pc_r + 32'd8;
  assign br_tgt = pc4 + {imm[29:0], 2'b00};
  assign j_tgt  = (pc4 & miis_pkg::REGION_MASK) | {4'b0, ex_r.iw[25:0], 2'b00};
  assign prod   = a[31:0] * b[31:0];

  always_comb begin
    ld_v = ex_r.load_data;
    case (lk_r)
      miis_pkg::LK_LBU: ld_v = {56'b0, ex_r.load_data[7:0]};
      miis_pkg::LK_LHU: ld_v = {48'b0, ex_r.load_data[15:0]};
      miis_pkg::LK_LW:  ld_v = miis_pkg::sx32(ex_r.load_data);
      miis_pkg::LK_LWU: ld_v = {32'b0, ex_r.load_data[31:0]};
      default:          ld_v = ex_r.load_data;
    endcase
  end

  always_comb begin
    wr_en  = 1'b0;
    wr_a   = rt;
    wr_d   = '0;
    take   = 1'b0;
    nf     = npc_r;
    mul_en = 1'b0;
    lk_nxt = miis_pkg::LK_NONE;
    lt_nxt = lt_r;
    t32    = '0;
    res    = '0;
    res.status = ex_r.unimpl ? miis_pkg::ST_UNIMPL : miis_pkg::ST_DONE;

    if (ex_r.is_data) begin
      // data with no load pending is dropped
      wr_en  = (lk_r != miis_pkg::LK_NONE);
      wr_a   = lt_r;
      wr_d   = ld_v;
      lk_nxt = miis_pkg::LK_NONE;
    end else begin
      case (op)
        miis_pkg::OP_SPECIAL: begin
          wr_a  = rd;
          wr_en = 1'b1;
          case (fn)
            miis_pkg::F_SLL: begin
              t32  = b[31:0] << sa;
              wr_d = miis_pkg::sx32({32'b0, t32});
            end
            miis_pkg::F_SRL: begin
              t32  = b[31:0] >> sa;
              wr_d = miis_pkg::sx32({32'b0, t32});
            end
            miis_pkg::F_SRA:  wr_d = miis_pkg::sx32(b >> sa);
            miis_pkg::F_SLLV: begin
              t32  = b[31:0] << a[4:0];
              wr_d = miis_pkg::sx32({32'b0, t32});
            end
            miis_pkg::F_SRLV: begin
              t32  = b[31:0] >> a[4:0];
              wr_d = miis_pkg::sx32({32'b0, t32});
            end
            miis_pkg::F_SRAV: wr_d = miis_pkg::sx32(b >> a[4:0]);
            miis_pkg::F_JR: begin
              wr_en = 1'b0;
              take  = 1'b1;
              nf    = a[31:0];
            end
            miis_pkg::F_JALR: begin
              take = 1'b1;
              nf   = a[31:0];
              wr_d = {32'b0, link32};
            end
            miis_pkg::F_MFLO:  wr_d = lo_r;
            miis_pkg::F_DSLLV: wr_d = b << a[5:0];
            miis_pkg::F_MULTU: begin
              wr_en  = 1'b0;
              mul_en = 1'b1;
            end
            miis_pkg::F_ADD, miis_pkg::F_ADDU: wr_d = miis_pkg::sx32(a + b);
            miis_pkg::F_SUBU:   wr_d = miis_pkg::sx32(a - b);
            miis_pkg::F_AND:    wr_d = a & b;
            miis_pkg::F_OR:     wr_d = a | b;
            miis_pkg::F_XOR:    wr_d = a ^ b;
            miis_pkg::F_NOR:    wr_d = ~(a | b);
            miis_pkg::F_SLT:    wr_d = {63'b0, ($signed(a) < $signed(b))};
            miis_pkg::F_SLTU:   wr_d = {63'b0, (a < b)};
            miis_pkg::F_DSLL:   wr_d = b << sa;
            miis_pkg::F_DSLL32: wr_d = b << {1'b1, sa};
            miis_pkg::F_DSRA32: wr_d = 64'($signed(b) >>> {1'b1, sa});
            default:            wr_en = 1'b0;
          endcase
        end
        miis_pkg::OP_REGIMM: begin
          if (rt == miis_pkg::RT_BGEZAL) begin
            take  = !a[63];
            nf    = !a[63] ? br_tgt : npc_r;
            wr_en = 1'b1;
            wr_a  = miis_pkg::LINK_REG;
            wr_d  = {32'b0, link32};
          end
        end
        miis_pkg::OP_J: begin
          take = 1'b1;
          nf   = j_tgt;
        end
        miis_pkg::OP_JAL: begin
          take  = 1'b1;
          nf    = j_tgt;
          wr_en = 1'b1;
          wr_a  = miis_pkg::LINK_REG;
          wr_d  = {32'b0, link32};
        end
        miis_pkg::OP_BEQ, miis_pkg::OP_BNE, miis_pkg::OP_BEQL, miis_pkg::OP_BNEL: begin
          take = (op == miis_pkg::OP_BEQ || op == miis_pkg::OP_BEQL) ? (a == b) : (a != b);
          if (take) begin
            nf = br_tgt;
          end else if (op == miis_pkg::OP_BEQL || op == miis_pkg::OP_BNEL) begin
            // likely branch not taken: skip the delay slot
            nf = npc_r + 32'd4;
          end
        end
        miis_pkg::OP_ADDI, miis_pkg::OP_ADDIU: begin
          wr_en = 1'b1;
          wr_d  = miis_pkg::sx32(a + imm);
        end
        miis_pkg::OP_SLTI: begin
          wr_en = 1'b1;
          wr_d  = {63'b0, ($signed(a) < $signed(imm))};
        end
        miis_pkg::OP_SLTIU: begin
          wr_en = 1'b1;
          wr_d  = {63'b0, (a < imm)};
        end
        miis_pkg::OP_ANDI: begin
          wr_en = 1'b1;
          wr_d  = a & zimm;
        end
        miis_pkg::OP_ORI: begin
          wr_en = 1'b1;
          wr_d  = a | zimm;
        end
        miis_pkg::OP_XORI: begin
          wr_en = 1'b1;
          wr_d  = a ^ zimm;
        end
        miis_pkg::OP_LUI: begin
          wr_en = 1'b1;
          wr_d  = miis_pkg::sx32({32'b0, ex_r.iw[15:0], 16'b0});
        end
        miis_pkg::OP_DADDI, miis_pkg::OP_DADDIU: begin
          wr_en = 1'b1;
          wr_d  = a + imm;
        end
        miis_pkg::OP_LW, miis_pkg::OP_LBU, miis_pkg::OP_LHU, miis_pkg::OP_LWU,
        miis_pkg::OP_LD: begin
          res.status      = miis_pkg::ST_LOAD;
          res.mem_read    = 1'b1;
          res.mem_address = a[31:0] + imm[31:0];
          lt_nxt          = rt;
          case (op)
            miis_pkg::OP_LBU: begin
              lk_nxt = miis_pkg::LK_LBU;
              res.mem_size = miis_pkg::SZ_BYTE;
            end
            miis_pkg::OP_LHU: begin
              lk_nxt = miis_pkg::LK_LHU;
              res.mem_size = miis_pkg::SZ_HALF;
            end
            miis_pkg::OP_LWU: begin
              lk_nxt = miis_pkg::LK_LWU;
              res.mem_size = miis_pkg::SZ_WORD;
            end
            miis_pkg::OP_LD: begin
              lk_nxt = miis_pkg::LK_LD;
              res.mem_size = miis_pkg::SZ_DBL;
            end
            default: begin
              lk_nxt = miis_pkg::LK_LW;
              res.mem_size = miis_pkg::SZ_WORD;
            end
          endcase
        end
        miis_pkg::OP_SW: begin
          res.mem_write   = 1'b1;
          res.mem_size    = miis_pkg::SZ_WORD;
          res.mem_address = a[31:0] + imm[31:0];
          res.store_data  = b[31:0];
        end
        default: ;
      endcase
    end

    wr_en = wr_en && (wr_a != '0);

    if (ex_r.is_data) begin
      pc_nxt  = pc_r;
      npc_nxt = npc_r;
    end else if (take) begin
      pc_nxt  = pc4;
      npc_nxt = nf;
    end else begin
      pc_nxt  = nf;
      npc_nxt = nf + 32'd4;
    end
    res.fetch_address = pc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_v_r    <= 1'b0;
      out_valid <= 1'b0;
      pc_r      <= miis_pkg::BOOT_PC;
      npc_r     <= miis_pkg::BOOT_PC + 32'd4;
      hi_r      <= miis_pkg::BOOT_HI;
      lo_r      <= miis_pkg::BOOT_LO;
      lk_r      <= miis_pkg::LK_NONE;
      lt_r      <= '0;
      vld_r     <= '0;
      fwd_v_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        ex_v_r <= 1'b1;
      end else if (fire) begin
        ex_v_r <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        pc_r  <= cfg_data;
        npc_r <= cfg_data + 32'd4;
        lk_r  <= miis_pkg::LK_NONE;
        lt_r  <= '0;
      end else if (fire) begin
        pc_r  <= pc_nxt;
        npc_r <= npc_nxt;
        lk_r  <= lk_nxt;
        lt_r  <= lt_nxt;
      end
      if (fire && mul_en) begin
        hi_r <= miis_pkg::sx32({32'b0, prod[63:32]});
        lo_r <= miis_pkg::sx32(prod);
      end
      if (w_go) begin
        vld_r[wr_a] <= 1'b1;
        fwd_v_r     <= 1'b1;
      end
    end
    if (q_pop) begin
      ex_r <= q_item;
    end
    if (w_go) begin
      fwd_a_r <= wr_a;
      fwd_d_r <= wr_d;
    end
    if (fire) begin
      out_res <= res;
    end
  end

endmodule

@@ hdl/mips_integer_instruction_step.sv @@
// Top level of the MIPS III integer instruction step block.
//
// Usage:
//   Input channel (in_*): one item per handshake, either an instruction word
//   fetched at the current fetch address (in_opcode 0) or the data for the
//   pending load (in_opcode 1). Every item yields exactly one result item on
//   the out_* channel: status, next fetch address and an optional memory
//   request. The receiver sends the next instruction from out_fetch_address.
//   Path: an accepted item waits in the front queue, moves to execute when
//   popped (register file read), and its result is then registered.
//   Throughput: one item per cycle while out_ready stays high; execute
//   reads the register file via a registered port, forwards the latest write.
//   Receiver stall: the result register holds, execute holds, and the
//   front queue absorbs new items until it is full, then in_ready drops.
//   Reset: pc = 0xA4000040, register file and hi/lo take their boot values
//   (a valid bit per register selects the boot table until first write).
//   cfg_we loads a new start pc and drops any pending load; write it idle.
module mips_integer_instruction_step #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_instruction_word,
  input  logic [63:0] in_load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_fetch_address,
  output logic        out_mem_read,
  output logic        out_mem_write,
  output logic [1:0]  out_mem_size,
  output logic [31:0] out_mem_address,
  output logic [31:0] out_store_data
);

  logic              q_valid;
  logic              q_pop;
  miis_pkg::item_t   q_item;
  miis_pkg::result_t res;

  // front: accept, classify, queue
  miis_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_instruction_word (in_instruction_word),
    .in_load_data        (in_load_data),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop)
  );

  // back: execute, update state, hold the result
  miis_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_status        = res.status;
  assign out_fetch_address = res.fetch_address;
  assign out_mem_read      = res.mem_read;
  assign out_mem_write     = res.mem_write;
  assign out_mem_size      = res.mem_size;
  assign out_mem_address   = res.mem_address;
  assign out_store_data    = res.store_data;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_mem_read && out_mem_write))
    else $error("load and store issued together");

  a_load_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == miis_pkg::ST_LOAD) == out_mem_read))
    else $error("load status and read request disagree");

  a_no_request_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_mem_read && !out_mem_write) |-> (out_mem_address == '0))
    else $error("address driven without a memory request");

endmodule

@@ tb/miis_step_checker.sv @@
// Checker for the MIPS integer step block: predicts each result item and compares it.
`timescale 1ns / 100ps

module miis_step_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_instruction_word,
  input  logic [63:0] in_load_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_fetch_address,
  input  logic        out_mem_read,
  input  logic        out_mem_write,
  input  logic [1:0]  out_mem_size,
  input  logic [31:0] out_mem_address,
  input  logic [31:0] out_store_data,
  output int          fail_count,
  output int          results_owed
);

  logic [63:0] gpr [32];
  logic [63:0] hi_q, lo_q;
  logic [31:0] pc_q, next_pc_q;
  logic        branch_q;
  logic [4:0]  load_reg_q;
  logic [2:0]  load_kind_q;
  miis_pkg::result_t owed_q [$];

  task automatic boot_state();
    gpr = '{64'h0, 64'h1, 64'hEBDA536, 64'hEBDA536, 64'hA536,
            64'hFFFFFFFFC0F1D859, 64'hFFFFFFFFA4001F0C, 64'hFFFFFFFFA4001F08,
            64'hC0, 64'h0, 64'h40, 64'hFFFFFFFFA4000040, 64'hFFFFFFFFED10D0B3,
            64'h1402A4CC, 64'h2DE108EA, 64'h3103E121, 64'h0, 64'h0, 64'h0, 64'h0,
            64'h1, 64'h0, 64'h3F, 64'h0, 64'h0, 64'hFFFFFFFF9DEBB54F, 64'h0, 64'h0,
            64'h0, 64'hFFFFFFFFA4001FF0, 64'h0, 64'hFFFFFFFFA4001550};
    hi_q        = miis_pkg::BOOT_HI;
    lo_q        = miis_pkg::BOOT_LO;
    pc_q        = miis_pkg::BOOT_PC;
    next_pc_q   = miis_pkg::BOOT_PC + 32'd4;
    branch_q    = 1'b0;
    load_reg_q  = '0;
    load_kind_q = miis_pkg::LK_NONE;
  endtask

  function automatic logic [63:0] ext_word(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  task automatic put_reg(input logic [4:0] idx, input logic [63:0] v);
    if (idx != 5'd0) gpr[idx] = v;
  endtask

  task automatic take_branch(input logic taken, input logic likely, input logic [31:0] iw);
    if (taken) begin
      next_pc_q = pc_q + 32'd4 + {{14{iw[15]}}, iw[15:0], 2'b00};
      branch_q  = 1'b1;
    end else if (likely) begin
      next_pc_q = next_pc_q + 32'd4;
    end
  endtask

  task automatic jump_to(input logic [31:0] target);
    next_pc_q = target;
    branch_q  = 1'b1;
  endtask

  // Step the core model by one item and return the result it produces.
  task automatic step_core(input logic is_data, input logic [31:0] iw, input logic [63:0] d,
                           output miis_pkg::result_t r);
    logic [4:0]   rs, rt, rd, sa;
    logic [63:0]  a, b, imm, zimm, prod;
    logic [31:0]  addr, link;
    r = '0;
    if (is_data) begin
      case (load_kind_q)
        miis_pkg::LK_NONE: ;
        miis_pkg::LK_LBU:  put_reg(load_reg_q, {56'b0, d[7:0]});
        miis_pkg::LK_LHU:  put_reg(load_reg_q, {48'b0, d[15:0]});
        miis_pkg::LK_LW:   put_reg(load_reg_q, ext_word(d[31:0]));
        miis_pkg::LK_LWU:  put_reg(load_reg_q, {32'b0, d[31:0]});
        default:           put_reg(load_reg_q, d);
      endcase
      load_kind_q = miis_pkg::LK_NONE;
      r.fetch_address = pc_q;
      return;
    end
    load_kind_q = miis_pkg::LK_NONE;
    rs   = iw[25:21];
    rt   = iw[20:16];
    rd   = iw[15:11];
    sa   = iw[10:6];
    a    = gpr[rs];
    b    = gpr[rt];
    imm  = {{48{iw[15]}}, iw[15:0]};
    zimm = {48'b0, iw[15:0]};
    addr = a[31:0] + imm[31:0];
    link = pc_q + 32'd8;
    r.status = miis_pkg::ST_DONE;
    case (iw[31:26])
      miis_pkg::OP_SPECIAL: begin
        case (iw[5:0])
          miis_pkg::F_SLL:    put_reg(rd, ext_word(b[31:0] << sa));
          miis_pkg::F_SRL:    put_reg(rd, ext_word(b[31:0] >> sa));
          miis_pkg::F_SRA:    put_reg(rd, ext_word(32'(b >> sa)));
          miis_pkg::F_SLLV:   put_reg(rd, ext_word(b[31:0] << a[4:0]));
          miis_pkg::F_SRLV:   put_reg(rd, ext_word(b[31:0] >> a[4:0]));
          miis_pkg::F_SRAV:   put_reg(rd, ext_word(32'(b >> a[4:0])));
          miis_pkg::F_JR:     jump_to(a[31:0]);
          miis_pkg::F_JALR: begin
            jump_to(a[31:0]);
            put_reg(rd, {32'b0, link});
          end
          miis_pkg::F_MFLO:   put_reg(rd, lo_q);
          miis_pkg::F_DSLLV:  put_reg(rd, b << a[5:0]);
          miis_pkg::F_MULTU: begin
            prod = {32'b0, a[31:0]} * {32'b0, b[31:0]};
            hi_q = ext_word(prod[63:32]);
            lo_q = ext_word(prod[31:0]);
          end
          miis_pkg::F_ADD, miis_pkg::F_ADDU: put_reg(rd, ext_word(a[31:0] + b[31:0]));
          miis_pkg::F_SUBU:   put_reg(rd, ext_word(a[31:0] - b[31:0]));
          miis_pkg::F_AND:    put_reg(rd, a & b);
          miis_pkg::F_OR:     put_reg(rd, a | b);
          miis_pkg::F_XOR:    put_reg(rd, a ^ b);
          miis_pkg::F_NOR:    put_reg(rd, ~(a | b));
          miis_pkg::F_SLT:    put_reg(rd, {63'b0, $signed(a) < $signed(b)});
          miis_pkg::F_SLTU:   put_reg(rd, {63'b0, a < b});
          miis_pkg::F_DSLL:   put_reg(rd, b << sa);
          miis_pkg::F_DSLL32: put_reg(rd, b << (32 + sa));
          miis_pkg::F_DSRA32: put_reg(rd, $unsigned($signed(b) >>> (32 + sa)));
          default:            r.status = miis_pkg::ST_UNIMPL;
        endcase
      end
      miis_pkg::OP_REGIMM: begin
        if (rt != miis_pkg::RT_BGEZAL) begin
          r.status = miis_pkg::ST_UNIMPL;
        end else begin
          take_branch(!a[63], 1'b0, iw);
          put_reg(miis_pkg::LINK_REG, {32'b0, link});
        end
      end
      miis_pkg::OP_COP0: if (rs != miis_pkg::RS_MTC0) r.status = miis_pkg::ST_UNIMPL;
      miis_pkg::OP_J:
        jump_to(((pc_q + 32'd4) & miis_pkg::REGION_MASK) | {4'b0, iw[25:0], 2'b00});
      miis_pkg::OP_JAL: begin
        jump_to(((pc_q + 32'd4) & miis_pkg::REGION_MASK) | {4'b0, iw[25:0], 2'b00});
        put_reg(miis_pkg::LINK_REG, {32'b0, link});
      end
      miis_pkg::OP_BEQ:    take_branch(a == b, 1'b0, iw);
      miis_pkg::OP_BNE:    take_branch(a != b, 1'b0, iw);
      miis_pkg::OP_BEQL:   take_branch(a == b, 1'b1, iw);
      miis_pkg::OP_BNEL:   take_branch(a != b, 1'b1, iw);
      miis_pkg::OP_ADDI, miis_pkg::OP_ADDIU: put_reg(rt, ext_word(a[31:0] + imm[31:0]));
      miis_pkg::OP_SLTI:   put_reg(rt, {63'b0, $signed(a) < $signed(imm)});
      miis_pkg::OP_SLTIU:  put_reg(rt, {63'b0, a < imm});
      miis_pkg::OP_ANDI:   put_reg(rt, a & zimm);
      miis_pkg::OP_ORI:    put_reg(rt, a | zimm);
      miis_pkg::OP_XORI:   put_reg(rt, a ^ zimm);
      miis_pkg::OP_LUI:    put_reg(rt, ext_word({iw[15:0], 16'b0}));
      miis_pkg::OP_DADDI, miis_pkg::OP_DADDIU: put_reg(rt, a + imm);
      miis_pkg::OP_LW, miis_pkg::OP_LBU, miis_pkg::OP_LHU, miis_pkg::OP_LWU,
      miis_pkg::OP_LD: begin
        case (iw[31:26])
          miis_pkg::OP_LW: begin
            load_kind_q = miis_pkg::LK_LW;
            r.mem_size  = miis_pkg::SZ_WORD;
          end
          miis_pkg::OP_LBU: begin
            load_kind_q = miis_pkg::LK_LBU;
            r.mem_size  = miis_pkg::SZ_BYTE;
          end
          miis_pkg::OP_LHU: begin
            load_kind_q = miis_pkg::LK_LHU;
            r.mem_size  = miis_pkg::SZ_HALF;
          end
          miis_pkg::OP_LWU: begin
            load_kind_q = miis_pkg::LK_LWU;
            r.mem_size  = miis_pkg::SZ_WORD;
          end
          default: begin
            load_kind_q = miis_pkg::LK_LD;
            r.mem_size  = miis_pkg::SZ_DBL;
          end
        endcase
        load_reg_q    = rt;
        r.mem_read    = 1'b1;
        r.mem_address = addr;
        r.status      = miis_pkg::ST_LOAD;
      end
      miis_pkg::OP_SW: begin
        r.mem_write   = 1'b1;
        r.mem_size    = miis_pkg::SZ_WORD;
        r.mem_address = addr;
        r.store_data  = b[31:0];
      end
      miis_pkg::OP_CACHE: ;
      default:   r.status = miis_pkg::ST_UNIMPL;
    endcase
    // Advance through the delay slot, or follow the queued target.
    if (!branch_q) begin
      pc_q      = next_pc_q;
      next_pc_q = next_pc_q + 32'd4;
    end else begin
      pc_q     = pc_q + 32'd4;
      branch_q = 1'b0;
    end
    r.fetch_address = pc_q;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    miis_pkg::result_t got, want;
    if (!rst_n) begin
      boot_state();
      owed_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        pc_q        = cfg_data;
        next_pc_q   = cfg_data + 32'd4;
        branch_q    = 1'b0;
        load_kind_q = miis_pkg::LK_NONE;
        load_reg_q  = '0;
      end
      if (out_valid && out_ready) begin
        got = '{out_status, out_fetch_address, out_mem_read, out_mem_write,
                out_mem_size, out_mem_address, out_store_data};
        if (owed_q.size() == 0) begin
          report_mismatch("unexpected result item", 64'(got.fetch_address), 64'h0);
        end else begin
          want = owed_q.pop_front();
          if (got.status != want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.fetch_address != want.fetch_address)
            report_mismatch("fetch_address", 64'(got.fetch_address), 64'(want.fetch_address));
          if (got.mem_read != want.mem_read)
            report_mismatch("mem_read", 64'(got.mem_read), 64'(want.mem_read));
          if (got.mem_write != want.mem_write)
            report_mismatch("mem_write", 64'(got.mem_write), 64'(want.mem_write));
          if (got.mem_size != want.mem_size)
            report_mismatch("mem_size", 64'(got.mem_size), 64'(want.mem_size));
          if (got.mem_address != want.mem_address)
            report_mismatch("mem_address", 64'(got.mem_address), 64'(want.mem_address));
          if (got.store_data != want.store_data)
            report_mismatch("store_data", 64'(got.store_data), 64'(want.store_data));
        end
      end
      if (in_valid && in_ready) begin
        step_core(in_opcode, in_instruction_word, in_load_data, want);
        owed_q.push_back(want);
      end
    end
    results_owed = owed_q.size();
  end

endmodule

@@ tb/mips_integer_instruction_step_test.sv @@
// Testbench top for the MIPS integer step block: stimulus, idling phases and verdict.
`timescale 1ns / 100ps

module mips_integer_instruction_step_test;

  localparam int ITEMS_PER_PHASE = 230;
  localparam int STALL_LIMIT     = 2000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [31:0] in_instruction_word;
  logic [63:0] in_load_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_fetch_address;
  logic        out_mem_read;
  logic        out_mem_write;
  logic [1:0]  out_mem_size;
  logic [31:0] out_mem_address;
  logic [31:0] out_store_data;

  int fail_count;
  int results_owed;
  int idle_pct;       // chance per cycle that the sender pauses
  int stall_pct;      // chance per cycle that the receiver holds off
  int hold_off;       // request for a long receiver hold-off, in cycles
  int quiet_cycles;

  mips_integer_instruction_step dut (
    .clk, .rst_n, .cfg_we, .cfg_data,
    .in_valid, .in_ready, .in_opcode, .in_instruction_word, .in_load_data,
    .out_valid, .out_ready, .out_status, .out_fetch_address, .out_mem_read,
    .out_mem_write, .out_mem_size, .out_mem_address, .out_store_data
  );

  miis_step_checker u_checker (
    .clk, .rst_n, .cfg_we, .cfg_data,
    .in_valid, .in_ready, .in_opcode, .in_instruction_word, .in_load_data,
    .out_valid, .out_ready, .out_status, .out_fetch_address, .out_mem_read,
    .out_mem_write, .out_mem_size, .out_mem_address, .out_store_data,
    .fail_count, .results_owed
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off on request so the block
  // fills its queue and pushes back on the sender.
  initial begin
    int held;
    held = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        held     = hold_off;
        hold_off = 0;
      end
      if (held > 0) begin
        held--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[mips_integer_instruction_step] ERROR");
      $finish;
    end
  end

  // Offer one item and return at the edge that accepts it; valid stays high.
  task automatic send_item(input logic is_data, input logic [31:0] iw, input logic [63:0] d);
    logic rdy;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_opcode           <= is_data;
    in_instruction_word <= iw;
    in_load_data        <= d;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // Drain all owed results, let the pipeline settle, then load a new start pc.
  task automatic restart_at(input logic [31:0] pc);
    in_valid <= 1'b0;
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_data <= pc;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [4:0] pick_reg();
    // Favor a few low registers so results feed later instructions.
    return ($urandom_range(1) != 0) ? 5'($urandom_range(7)) : 5'($urandom);
  endfunction

  function automatic logic [31:0] r_type(input logic [5:0] fn);
    return {miis_pkg::OP_SPECIAL, pick_reg(), pick_reg(), pick_reg(), 5'($urandom), fn};
  endfunction

  function automatic logic [31:0] i_type(input logic [5:0] op);
    return {op, pick_reg(), pick_reg(), 16'($urandom)};
  endfunction

  function automatic logic [31:0] random_instruction();
    logic [5:0] fns [23];
    logic [5:0] ops [23];
    int pick;
    fns = '{miis_pkg::F_SLL, miis_pkg::F_SRL, miis_pkg::F_SRA, miis_pkg::F_SLLV,
            miis_pkg::F_SRLV, miis_pkg::F_SRAV, miis_pkg::F_JR, miis_pkg::F_JALR,
            miis_pkg::F_MFLO, miis_pkg::F_DSLLV, miis_pkg::F_MULTU, miis_pkg::F_ADD,
            miis_pkg::F_ADDU, miis_pkg::F_SUBU, miis_pkg::F_AND, miis_pkg::F_OR,
            miis_pkg::F_XOR, miis_pkg::F_NOR, miis_pkg::F_SLT, miis_pkg::F_SLTU,
            miis_pkg::F_DSLL, miis_pkg::F_DSLL32, miis_pkg::F_DSRA32};
    ops = '{miis_pkg::OP_J, miis_pkg::OP_JAL, miis_pkg::OP_BEQ, miis_pkg::OP_BNE,
            miis_pkg::OP_ADDI, miis_pkg::OP_ADDIU, miis_pkg::OP_SLTI, miis_pkg::OP_SLTIU,
            miis_pkg::OP_ANDI, miis_pkg::OP_ORI, miis_pkg::OP_XORI, miis_pkg::OP_LUI,
            miis_pkg::OP_BEQL, miis_pkg::OP_BNEL, miis_pkg::OP_DADDI, miis_pkg::OP_DADDIU,
            miis_pkg::OP_LW, miis_pkg::OP_LBU, miis_pkg::OP_LHU, miis_pkg::OP_LWU,
            miis_pkg::OP_SW, miis_pkg::OP_CACHE, miis_pkg::OP_LD};
    pick = $urandom_range(99);
    if (pick < 40) return r_type(fns[$urandom_range(22)]);
    if (pick < 85) return i_type(ops[$urandom_range(22)]);
    if (pick < 90) return {miis_pkg::OP_REGIMM, pick_reg(), miis_pkg::RT_BGEZAL, 16'($urandom)};
    if (pick < 93) return {miis_pkg::OP_COP0, miis_pkg::RS_MTC0, 21'($urandom)};
    return $urandom;    // mostly unimplemented encodings
  endfunction

  task automatic random_traffic(input int count);
    logic [31:0] iw;
    repeat (count) begin
      iw = random_instruction();
      send_item(1'b0, iw, {$urandom, $urandom});
      // Answer most loads; sometimes abandon them or send stray data.
      if (iw[31:26] inside {miis_pkg::OP_LW, miis_pkg::OP_LBU, miis_pkg::OP_LHU,
                            miis_pkg::OP_LWU, miis_pkg::OP_LD}) begin
        if ($urandom_range(9) < 8) send_item(1'b1, $urandom, {$urandom, $urandom});
      end else if ($urandom_range(19) == 0) begin
        send_item(1'b1, $urandom, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    in_valid            = 1'b0;
    in_opcode           = 1'b0;
    in_instruction_word = '0;
    in_load_data        = '0;
    idle_pct            = 0;
    stall_pct           = 0;
    hold_off            = 0;
    quiet_cycles        = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: boot state, special encodings, loads, links and delay slots.
    send_item(1'b1, '0, 64'hFFFF_FFFF_FFFF_FFFF);                  // data, no load pending
    send_item(1'b0, {miis_pkg::OP_COP0, miis_pkg::RS_MTC0, 21'h1F_FFFF}, '0); // mtc0
    send_item(1'b0, {miis_pkg::OP_CACHE, 26'h3FF_FFFF}, '0);       // cache does nothing
    send_item(1'b0, 32'hFFFF_FFFF, '0);                            // unimplemented
    send_item(1'b0, {miis_pkg::OP_REGIMM, 5'd1, 5'd0, 16'h0}, '0); // unimplemented regimm
    send_item(1'b0, {miis_pkg::OP_LUI, 5'd0, 5'd1, 16'hFFFF}, '0);
    send_item(1'b0, {miis_pkg::OP_ORI, 5'd1, 5'd1, 16'hFFFF}, '0); // r1 = sext all ones
    send_item(1'b0, {miis_pkg::OP_SPECIAL, 5'd1, 5'd1, 5'd0, 5'd0, miis_pkg::F_MULTU}, '0);
    send_item(1'b0, {miis_pkg::OP_SPECIAL, 5'd0, 5'd0, 5'd2, 5'd0, miis_pkg::F_MFLO}, '0);
    send_item(1'b0, {miis_pkg::OP_LW, 5'd1, 5'd3, 16'h8000}, '0);
    send_item(1'b1, '0, 64'h1234_5678_8000_0000);                  // lw sign extends
    send_item(1'b0, {miis_pkg::OP_LD, 5'd0, 5'd4, 16'h7FFF}, '0);
    send_item(1'b1, '0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(1'b0, {miis_pkg::OP_LBU, 5'd2, 5'd5, 16'h0001}, '0);
    send_item(1'b0, {miis_pkg::OP_ADDIU, 5'd0, 5'd6, 16'h0004}, '0); // abandons the load
    send_item(1'b1, '0, 64'hAAAA_AAAA_AAAA_AAAA);                  // stray now
    send_item(1'b0, {miis_pkg::OP_SW, 5'd29, 5'd1, 16'hFFFC}, '0);
    // jalr reads rs before the link write
    send_item(1'b0, {miis_pkg::OP_SPECIAL, 5'd31, 5'd0, 5'd31, 5'd0, miis_pkg::F_JALR}, '0);
    send_item(1'b0, {miis_pkg::OP_SPECIAL, 26'h0}, '0);            // delay slot
    send_item(1'b0, {miis_pkg::OP_REGIMM, 5'd31, miis_pkg::RT_BGEZAL, 16'hFFFF}, '0);
    send_item(1'b0, {miis_pkg::OP_JAL, 26'h3FF_FFFF}, '0);         // jump in the delay slot
    send_item(1'b0, {miis_pkg::OP_BEQL, 5'd0, 5'd1, 16'h0010}, '0); // likely, not taken
    send_item(1'b0, {miis_pkg::OP_BNEL, 5'd0, 5'd1, 16'h8000}, '0); // likely, taken
    send_item(1'b0, {miis_pkg::OP_J, 26'h0}, '0);

    // Random phases, each from a fresh start pc, extremes included.
    restart_at(32'h0000_0000);
    idle_pct  = 0;
    stall_pct = 0;
    random_traffic(ITEMS_PER_PHASE);

    restart_at(32'hFFFF_FFFC);
    idle_pct  = 74;
    stall_pct = 0;
    random_traffic(ITEMS_PER_PHASE);

    restart_at($urandom);
    idle_pct  = 0;
    stall_pct = 74;
    hold_off  = 200;    // keep offering while the receiver is held off
    random_traffic(ITEMS_PER_PHASE);

    restart_at(miis_pkg::BOOT_PC);
    idle_pct  = 31;
    stall_pct = 31;
    random_traffic(ITEMS_PER_PHASE);

    in_valid <= 1'b0;
    while (results_owed != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0)
      $display("[mips_integer_instruction_step] OK");
    else
      $display("[mips_integer_instruction_step] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/miis_pkg.sv
hdl/miis_ram.sv
hdl/miis_front.sv
hdl/miis_back.sv
hdl/mips_integer_instruction_step.sv
tb/miis_step_checker.sv
tb/mips_integer_instruction_step_test.sv
